// ===== sv/olid_pkg.sv =====
package olid_pkg;

	localparam int KIND_W = 3;
	localparam int POS_W  = 5;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 5;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND    = 3'd0,
		KIND_ERASE     = 3'd1,
		KIND_OVERWRITE = 3'd2,
		KIND_INSERT    = 3'd3,
		KIND_READ      = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_LEFT  = 2'd2,
		CELL_RIGHT = 2'd3
	} cell_op_t;

endpackage

// ===== sv/olid_cell.sv =====
module olid_cell #(
	parameter int W = 32
) (
	input  logic                clk,
	input  olid_pkg::cell_op_t  op,
	input  logic [W-1:0]        load_data,
	input  logic [W-1:0]        left_data,
	input  logic [W-1:0]        right_data,
	output logic [W-1:0]        data
);

	logic [W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			olid_pkg::CELL_LOAD:  data_q <= load_data;
			olid_pkg::CELL_LEFT:  data_q <= left_data;
			olid_pkg::CELL_RIGHT: data_q <= right_data;
			default:              data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ===== sv/ordered_list_insert_delete_core.sv =====
// A result appears on m_tvalid in the cycle after its request transaction.
// Throughput: one request per cycle while m_tready is high; every cell of the
// element row shifts, loads or holds at the same clock edge.
// Reset: the element count clears, capacity returns to 16 and the output
// register empties; element contents are left as they are.
module ordered_list_insert_delete_core #(
	parameter int MAX_ENTRIES = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg_data: capacity[4:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: position[4:0], value[36:5], zero[39:37]
	input  logic [39:0] s_tdata,
	// s_tuser: kind[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: read_data[31:0], count[36:32], zero[39:37]
	output logic [39:0] m_tdata,
	// m_tuser: ok[0]
	output logic        m_tuser
);

	localparam int SW = (DATA_WIDTH < olid_pkg::VAL_W) ? DATA_WIDTH : olid_pkg::VAL_W;
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int PW = ((CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W) + 1;

	logic [olid_pkg::CAP_W-1:0]  capacity_q;
	logic [CW-1:0]               used_q;
	logic                        m_tvalid_q;
	logic                        ok_q;
	logic [olid_pkg::VAL_W-1:0]  rdata_q;
	logic [olid_pkg::CNT_W-1:0]  count_q;

	olid_pkg::kind_t             kind;
	logic [olid_pkg::POS_W-1:0]  position;
	logic [olid_pkg::VAL_W-1:0]  value;
	logic [SW-1:0]               wr_data;

	logic [PW-1:0]               pos_x;
	logic [PW-1:0]               used_x;
	logic [PW-1:0]               lim_x;
	logic [PW-1:0]               cap_x;
	logic [PW-1:0]               ix;
	logic                        accept;
	logic                        in_list;
	logic                        room;
	logic                        ok;
	logic [CW-1:0]               used_next;
	logic [IW-1:0]               rd_idx;
	logic [olid_pkg::VAL_W-1:0]  rdata;

	logic [SW-1:0]               cell_data [MAX_ENTRIES];
	olid_pkg::cell_op_t          cell_op   [MAX_ENTRIES];

	assign kind     = olid_pkg::kind_t'(s_tuser);
	assign position = s_tdata[olid_pkg::POS_W-1:0];
	assign value    = s_tdata[olid_pkg::POS_W +: olid_pkg::VAL_W];
	assign wr_data  = value[SW-1:0];

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	assign pos_x   = PW'(position);
	assign used_x  = PW'(used_q);
	assign cap_x   = PW'(capacity_q);
	assign lim_x   = (cap_x < PW'(MAX_ENTRIES)) ? cap_x : PW'(MAX_ENTRIES);
	assign in_list = (pos_x != '0) && (pos_x <= used_x);
	assign room    = used_x < lim_x;
	assign rd_idx  = IW'(pos_x - PW'(1));

	always_comb begin
		ok        = 1'b0;
		used_next = used_q;
		rdata     = '0;
		case (kind)
			olid_pkg::KIND_APPEND: begin
				ok = room;
				if (room) used_next = used_q + CW'(1);
			end
			olid_pkg::KIND_ERASE: begin
				ok = in_list;
				if (in_list) used_next = used_q - CW'(1);
			end
			olid_pkg::KIND_OVERWRITE: begin
				ok = in_list;
			end
			olid_pkg::KIND_INSERT: begin
				ok = room && (pos_x <= used_x);
				if (ok) used_next = used_q + CW'(1);
			end
			olid_pkg::KIND_READ: begin
				ok = in_list;
				if (in_list) rdata = olid_pkg::VAL_W'(cell_data[rd_idx]);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		ix = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			ix         = PW'(i);
			cell_op[i] = olid_pkg::CELL_HOLD;
			if (accept && ok) begin
				case (kind)
					olid_pkg::KIND_APPEND: begin
						if (ix == used_x) cell_op[i] = olid_pkg::CELL_LOAD;
					end
					olid_pkg::KIND_ERASE: begin
						if ((ix + PW'(1) >= pos_x) && (ix + PW'(1) < used_x))
							cell_op[i] = olid_pkg::CELL_RIGHT;
					end
					olid_pkg::KIND_OVERWRITE: begin
						if (ix + PW'(1) == pos_x) cell_op[i] = olid_pkg::CELL_LOAD;
					end
					olid_pkg::KIND_INSERT: begin
						if (ix == pos_x)
							cell_op[i] = olid_pkg::CELL_LOAD;
						else if ((ix > pos_x) && (ix <= used_x))
							cell_op[i] = olid_pkg::CELL_LEFT;
					end
					default: begin
						cell_op[i] = olid_pkg::CELL_HOLD;
					end
				endcase
			end
		end
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		olid_cell #(
			.W (SW)
		) u_cell (
			.clk        (clk),
			.op         (cell_op[g]),
			.load_data  (wr_data),
			.left_data  (cell_data[(g > 0) ? g - 1 : g]),
			.right_data (cell_data[(g < MAX_ENTRIES - 1) ? g + 1 : g]),
			.data       (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= olid_pkg::CAP_RESET;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) capacity_q <= cfg_data;
			if (accept) begin
				used_q     <= used_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= ok;
			rdata_q <= rdata;
			count_q <= olid_pkg::CNT_W'(used_next);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {3'b000, count_q, rdata_q};

endmodule

// ===== sv/olid_chk.sv =====
module olid_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while result is stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after request transaction");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("refused request returned read data");

endmodule

bind ordered_list_insert_delete_core olid_chk u_olid_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/ordered_list_reply_check.sv =====
module ordered_list_reply_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [olid_pkg::CAP_W-1:0]   cfg_data,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [39:0]                  s_tdata,
	input  logic [2:0]                   s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [39:0]                  m_tdata,
	input  logic                         m_tuser,
	output int                           mismatches,
	output int                           outstanding,
	output logic [olid_pkg::CNT_W-1:0]   list_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic                       ok;
		logic [olid_pkg::VAL_W-1:0] read_data;
		logic [olid_pkg::CNT_W-1:0] count;
	} list_reply_t;

	list_reply_t                replies_due[$];
	logic [olid_pkg::VAL_W-1:0] words[DEPTH];
	logic [olid_pkg::CNT_W-1:0] used_q;
	logic [olid_pkg::CAP_W-1:0] cap_q;

	initial begin
		mismatches = 0;
		outstanding = 0;
		list_count = '0;
	end

	task automatic report(input string line);
		$display("%0t: %s", $realtime, line);
		mismatches++;
	endtask

	task automatic list_apply(input logic [olid_pkg::KIND_W-1:0] kind,
			input logic [olid_pkg::POS_W-1:0] pos,
			input logic [olid_pkg::VAL_W-1:0] val, output list_reply_t r);
		int   lim;
		logic in_list;
		r = '0;
		lim = (cap_q < DEPTH) ? int'(cap_q) : DEPTH;
		in_list = (pos >= 1) && (pos <= used_q);
		case (kind)
			olid_pkg::KIND_APPEND: begin
				if (used_q < lim) begin
					words[used_q] = val;
					used_q = used_q + 1'b1;
					r.ok = 1'b1;
				end
			end
			olid_pkg::KIND_ERASE: begin
				if (in_list) begin
					for (int i = pos; i < used_q; i++)
						words[i-1] = words[i];
					used_q = used_q - 1'b1;
					r.ok = 1'b1;
				end
			end
			olid_pkg::KIND_OVERWRITE: begin
				if (in_list) begin
					words[pos-1] = val;
					r.ok = 1'b1;
				end
			end
			olid_pkg::KIND_INSERT: begin
				if (pos <= used_q && used_q < lim) begin
					for (int i = used_q; i > pos; i--)
						words[i] = words[i-1];
					words[pos] = val;
					used_q = used_q + 1'b1;
					r.ok = 1'b1;
				end
			end
			olid_pkg::KIND_READ: begin
				if (in_list) begin
					r.read_data = words[pos-1];
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.count = used_q;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replies_due.delete();
			used_q = '0;
			cap_q = olid_pkg::CAP_RESET;
			outstanding = 0;
			list_count <= '0;
		end else begin : watch
			list_reply_t want;
			list_reply_t got;
			if (cfg_valid && cfg_ready)
				cap_q = cfg_data;
			if (m_tvalid && m_tready) begin
				got.ok = m_tuser;
				got.read_data = m_tdata[31:0];
				got.count = m_tdata[36:32];
				if (replies_due.size() == 0) begin
					report($sformatf("result with no request pending: ok=%0b data=%0h count=%0d",
						got.ok, got.read_data, got.count));
				end else begin
					want = replies_due.pop_front();
					if (got.ok !== want.ok)
						report($sformatf("ok: expected %0b, got %0b", want.ok, got.ok));
					if (got.read_data !== want.read_data)
						report($sformatf("read_data: expected %0h, got %0h",
							want.read_data, got.read_data));
					if (got.count !== want.count)
						report($sformatf("count: expected %0d, got %0d", want.count, got.count));
				end
			end
			if (s_tvalid && s_tready) begin
				list_apply(s_tuser, s_tdata[4:0], s_tdata[36:5], want);
				replies_due.insert(replies_due.size(), want);
			end
			outstanding = replies_due.size();
			list_count <= used_q;
		end
	end

endmodule

// ===== tb/ordered_list_insert_delete_core_test.sv =====
module ordered_list_insert_delete_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 140;
	localparam int PHASES      = 12;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [olid_pkg::CAP_W-1:0]  cfg_data;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [39:0]                 s_tdata;
	logic [2:0]                  s_tuser;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [39:0]                 m_tdata;
	logic                        m_tuser;

	int                          mismatches;
	int                          outstanding;
	logic [olid_pkg::CNT_W-1:0]  list_count;

	bit                tx_idle;
	bit                rx_idle;
	bit                hold_off_req;
	int                quiet;

	ordered_list_insert_delete_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ordered_list_reply_check reply_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.list_count (list_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_tready <= rx_idle ? ($urandom_range(0, 99) >= 29) : 1'b1;
			end
		end
	end

	task automatic send_item(input logic [olid_pkg::KIND_W-1:0] kind,
			input logic [olid_pkg::POS_W-1:0] pos,
			input logic [olid_pkg::VAL_W-1:0] val);
		while (tx_idle && $urandom_range(0, 99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b000, val, pos};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_capacity(input logic [olid_pkg::CAP_W-1:0] cap);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [olid_pkg::KIND_W-1:0] pick_kind(input bit grow);
		int r;
		r = $urandom_range(0, 99);
		if (r >= 95)
			return olid_pkg::KIND_W'($urandom_range(5, 7));
		if (grow) begin
			if (r < 30) return olid_pkg::KIND_APPEND;
			if (r < 55) return olid_pkg::KIND_INSERT;
			if (r < 65) return olid_pkg::KIND_ERASE;
			if (r < 75) return olid_pkg::KIND_OVERWRITE;
			return olid_pkg::KIND_READ;
		end
		if (r < 10) return olid_pkg::KIND_APPEND;
		if (r < 20) return olid_pkg::KIND_INSERT;
		if (r < 55) return olid_pkg::KIND_ERASE;
		if (r < 70) return olid_pkg::KIND_OVERWRITE;
		return olid_pkg::KIND_READ;
	endfunction

	function automatic logic [olid_pkg::POS_W-1:0] pick_pos(
			input logic [olid_pkg::KIND_W-1:0] kind, input int cnt);
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return olid_pkg::POS_W'($urandom_range(0, 31));
		if (kind == olid_pkg::KIND_INSERT)
			return olid_pkg::POS_W'($urandom_range(0, cnt + 1));
		if (r < 12)
			return (r < 9) ? '0 : olid_pkg::POS_W'(cnt + 1);
		return (cnt == 0) ? olid_pkg::POS_W'(1) : olid_pkg::POS_W'($urandom_range(1, cnt));
	endfunction

	function automatic logic [olid_pkg::VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 12) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		logic [olid_pkg::CAP_W-1:0]  caps[PHASES];
		bit                          grows[PHASES];
		logic [olid_pkg::KIND_W-1:0] kind;
		caps = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd16, 5'd1,
			5'd5, 5'd16, 5'd0, 5'd31, 5'd3, 5'd16};
		grows = '{1, 1, 0, 1, 1, 1, 0, 1, 0, 1, 0, 0};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_off_req = 1'b0;
		quiet = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(olid_pkg::KIND_READ, 5'd1, 32'h0);
		send_item(olid_pkg::KIND_ERASE, 5'd1, 32'h0);
		send_item(olid_pkg::KIND_INSERT, 5'd1, 32'h1234_5678);
		send_item(olid_pkg::KIND_APPEND, 5'd0, 32'h7FFF_FFFF);
		send_item(olid_pkg::KIND_APPEND, 5'd31, 32'h8000_0000);
		send_item(olid_pkg::KIND_INSERT, 5'd0, 32'hFFFF_FFFF);
		send_item(olid_pkg::KIND_INSERT, 5'd3, 32'h0000_0000);
		send_item(olid_pkg::KIND_INSERT, 5'd2, 32'h5555_5555);
		send_item(olid_pkg::KIND_OVERWRITE, 5'd0, 32'h1111_1111);
		send_item(olid_pkg::KIND_OVERWRITE, 5'd5, 32'hAAAA_AAAA);
		send_item(olid_pkg::KIND_OVERWRITE, 5'd6, 32'h2222_2222);
		send_item(olid_pkg::KIND_READ, 5'd0, 32'h0);
		for (int i = 1; i <= 5; i++)
			send_item(olid_pkg::KIND_READ, olid_pkg::POS_W'(i), 32'h0);
		send_item(olid_pkg::KIND_READ, 5'd31, 32'hFFFF_FFFF);
		send_item(olid_pkg::KIND_ERASE, 5'd1, 32'h0);
		send_item(olid_pkg::KIND_ERASE, 5'd4, 32'h0);
		send_item(olid_pkg::KIND_ERASE, 5'd2, 32'h0);
		send_item(3'd5, 5'd1, 32'hFFFF_FFFF);
		send_item(3'd6, 5'd31, 32'h0);
		send_item(3'd7, 5'd2, 32'hFFFF_FFFF);
		send_item(olid_pkg::KIND_READ, 5'd2, 32'h0);

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(caps[p]);
			tx_idle = (p != 4);
			rx_idle = (p != 4);
			if (p == 7)
				hold_off_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = pick_kind(grows[p]);
				send_item(kind, pick_pos(kind, int'(list_count)), pick_value());
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/olid_pkg.sv
sv/olid_cell.sv
sv/ordered_list_insert_delete_core.sv
sv/olid_chk.sv
tb/ordered_list_reply_check.sv
tb/ordered_list_insert_delete_core_test.sv
